>>> sv/csvc_pkg.sv
// Package for the composite-sync capture cropper: types, register map, reset values, color helper.
package csvc_pkg;

  // Window defaults
  localparam int WindowWidthDef  = 320;
  localparam int WindowHeightDef = 224;

  // Field widths
  localparam int PulseW   = 12;
  localparam int PixW     = 16;
  localparam int ShortCntW = 8;
  localparam int LineW    = 9;
  localparam int SkipW    = 8;
  localparam int CapW     = 17;
  localparam int ColW     = 9;
  localparam int RowW     = 8;

  // Register reset values
  localparam logic [PulseW-1:0]    ShortPulseMaxRst  = 12'd288;
  localparam logic [ShortCntW-1:0] MinShortPulsesRst = 8'd8;
  localparam logic [LineW-1:0]     LineTotalRst      = 9'd384;
  localparam logic [SkipW-1:0]     SkipLinesRst      = 8'd20;
  localparam logic [SkipW-1:0]     SkipPixelsRst     = 8'd32;
  localparam logic [CapW-1:0]      CaptureLimitRst   = 17'd128000;

  // Saturation limits
  localparam logic [ShortCntW-1:0] ShortCntMax = '1;
  localparam logic [LineW-1:0]     LineIdxMax  = '1;

  // Register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_SHORT_PULSE_MAX  = 3'd0,
    REG_MIN_SHORT_PULSES = 3'd1,
    REG_LINE_TOTAL       = 3'd2,
    REG_SKIP_LINES       = 3'd3,
    REG_SKIP_PIXELS      = 3'd4,
    REG_CAPTURE_LIMIT    = 3'd5
  } reg_idx_t;

  // Input kinds carried on tuser
  typedef enum logic {
    OP_PULSE = 1'b0,
    OP_PIXEL = 1'b1
  } op_t;

  // Capture phase
  typedef enum logic [1:0] {
    PH_VSYNC   = 2'd0,
    PH_START   = 2'd1,
    PH_CAPTURE = 2'd2
  } phase_t;

  // RGB555 (R low, B mid, G high) to RGB565, green widened by its top bit
  function automatic logic [PixW-1:0] to_rgb565(input logic [PixW-1:0] w);
    logic [4:0] r5;
    logic [4:0] b5;
    logic [4:0] g5;
    r5 = w[4:0];
    b5 = w[9:5];
    g5 = w[14:10];
    return {r5, g5, g5[4], b5};
  endfunction

endpackage

>>> sv/csync_video_capture_cropper.sv
// Composite-sync video capture cropper: vsync detection, line counting and RGB565 window output.
//
//  channel | direction | handshake              | payload
//  in_     | slave     | in_tvalid / in_tready   | tuser: opcode; tdata: pulse_width, pixel_word
//  out_    | master    | out_tvalid / out_tready | tdata: rgb565, column, row; tlast: frame_last
//  cfg_    | apb slave | psel, penable, pready   | six 32-bit registers at 4*i
//
// One item per cycle sustained unless the output stalls: a transfer lands in the input register,
// then updates the phase and counters and loads the output register.
// The input register advances whenever the output register is empty or being taken.
// A stalled output holds a full input register, which then holds in_tready low.
// Synchronous active-low reset returns to waiting for vsync with default registers.
module csync_video_capture_cropper #(
  parameter int WINDOW_WIDTH  = csvc_pkg::WindowWidthDef,
  parameter int WINDOW_HEIGHT = csvc_pkg::WindowHeightDef
) (
  input  logic        clk,
  input  logic        rst_n,
  // stream input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [11:0] pulse_width, [27:12] pixel_word, [31:28] zero
  input  logic        in_tuser,    // [0] opcode
  // stream output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // [15:0] pixel_rgb565, [24:16] column, [32:25] row, zero
  output logic        out_tlast,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [csvc_pkg::ColW-1:0]  WinWLast = csvc_pkg::ColW'(WINDOW_WIDTH - 1);
  localparam logic [csvc_pkg::LineW-1:0] WinHLast = csvc_pkg::LineW'(WINDOW_HEIGHT - 1);

  // Configuration registers
  logic [csvc_pkg::PulseW-1:0]    short_pulse_max_r;
  logic [csvc_pkg::ShortCntW-1:0] min_short_pulses_r;
  logic [csvc_pkg::LineW-1:0]     line_total_r;
  logic [csvc_pkg::SkipW-1:0]     skip_lines_r;
  logic [csvc_pkg::SkipW-1:0]     skip_pixels_r;
  logic [csvc_pkg::CapW-1:0]      capture_limit_r;

  csvc_pkg::reg_idx_t cfg_idx;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = csvc_pkg::reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Write registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_pulse_max_r  <= csvc_pkg::ShortPulseMaxRst;
      min_short_pulses_r <= csvc_pkg::MinShortPulsesRst;
      line_total_r       <= csvc_pkg::LineTotalRst;
      skip_lines_r       <= csvc_pkg::SkipLinesRst;
      skip_pixels_r      <= csvc_pkg::SkipPixelsRst;
      capture_limit_r    <= csvc_pkg::CaptureLimitRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        csvc_pkg::REG_SHORT_PULSE_MAX:  short_pulse_max_r  <= cfg_pwdata[11:0];
        csvc_pkg::REG_MIN_SHORT_PULSES: min_short_pulses_r <= cfg_pwdata[7:0];
        csvc_pkg::REG_LINE_TOTAL:       line_total_r       <= cfg_pwdata[8:0];
        csvc_pkg::REG_SKIP_LINES:       skip_lines_r       <= cfg_pwdata[7:0];
        csvc_pkg::REG_SKIP_PIXELS:      skip_pixels_r      <= cfg_pwdata[7:0];
        csvc_pkg::REG_CAPTURE_LIMIT:    capture_limit_r    <= cfg_pwdata[16:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_idx)
      csvc_pkg::REG_SHORT_PULSE_MAX:  cfg_prdata = {20'd0, short_pulse_max_r};
      csvc_pkg::REG_MIN_SHORT_PULSES: cfg_prdata = {24'd0, min_short_pulses_r};
      csvc_pkg::REG_LINE_TOTAL:       cfg_prdata = {23'd0, line_total_r};
      csvc_pkg::REG_SKIP_LINES:       cfg_prdata = {24'd0, skip_lines_r};
      csvc_pkg::REG_SKIP_PIXELS:      cfg_prdata = {24'd0, skip_pixels_r};
      csvc_pkg::REG_CAPTURE_LIMIT:    cfg_prdata = {15'd0, capture_limit_r};
      default:                        cfg_prdata = 32'd0;
    endcase
  end

  // Input register
  logic                         s1_valid_r;
  csvc_pkg::op_t                s1_op_r;
  logic [csvc_pkg::PulseW-1:0]  s1_pw_r;
  logic [csvc_pkg::PixW-1:0]    s1_word_r;
  logic                         out_free;
  logic                         s1_fire;

  assign out_free  = !out_tvalid || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r   <= csvc_pkg::op_t'(in_tuser);
      s1_pw_r   <= in_tdata[11:0];
      s1_word_r <= in_tdata[27:12];
    end
  end

  // Capture state
  csvc_pkg::phase_t               phase_r, phase_nxt;
  logic [csvc_pkg::ShortCntW-1:0] short_count_r, short_count_nxt;
  logic [csvc_pkg::LineW-1:0]     pixel_in_line_r, pixel_in_line_nxt;
  logic [csvc_pkg::LineW-1:0]     line_index_r, line_index_nxt;
  logic [csvc_pkg::CapW-1:0]      captured_r, captured_nxt;

  logic                         res_valid;
  logic [csvc_pkg::ColW-1:0]    col;
  logic [csvc_pkg::LineW-1:0]   row;
  logic                         last;
  logic                         in_window;
  logic                         done;
  logic [csvc_pkg::LineW:0]     pix_inc;
  logic                         is_long;

  assign col       = pixel_in_line_r - {1'b0, skip_pixels_r};
  assign row       = line_index_r - {1'b0, skip_lines_r};
  assign is_long   = s1_pw_r > short_pulse_max_r;
  assign pix_inc   = {1'b0, pixel_in_line_r} + 1'b1;
  assign in_window = (line_index_r >= {1'b0, skip_lines_r}) &&
                     (pixel_in_line_r >= {1'b0, skip_pixels_r}) &&
                     (row <= WinHLast) && (col <= WinWLast);
  assign last      = (row == WinHLast) && (col == WinWLast);

  // Advance phase and counters for the item in the input register
  always_comb begin
    phase_nxt         = phase_r;
    short_count_nxt   = short_count_r;
    pixel_in_line_nxt = pixel_in_line_r;
    line_index_nxt    = line_index_r;
    captured_nxt      = captured_r;
    res_valid         = 1'b0;
    done              = 1'b0;
    if (s1_fire) begin
      case (phase_r)
        csvc_pkg::PH_CAPTURE: begin
          if (s1_op_r == csvc_pkg::OP_PIXEL) begin
            res_valid = in_window;
            done      = in_window && last;
            if (pix_inc >= {1'b0, line_total_r}) begin
              pixel_in_line_nxt = '0;
              if (line_index_r != csvc_pkg::LineIdxMax) begin
                line_index_nxt = line_index_r + 1'b1;
              end
            end else begin
              pixel_in_line_nxt = pix_inc[csvc_pkg::LineW-1:0];
            end
            captured_nxt = captured_r + 1'b1;
            if (captured_nxt >= capture_limit_r || captured_nxt == '0) begin
              done = 1'b1;
            end
            if (done) begin
              phase_nxt       = csvc_pkg::PH_VSYNC;
              short_count_nxt = '0;
            end
          end
        end
        csvc_pkg::PH_START: begin
          if (s1_op_r == csvc_pkg::OP_PULSE && is_long) begin
            phase_nxt         = csvc_pkg::PH_CAPTURE;
            pixel_in_line_nxt = '0;
            line_index_nxt    = '0;
            captured_nxt      = '0;
          end
        end
        default: begin
          phase_nxt = csvc_pkg::PH_VSYNC;
          if (s1_op_r == csvc_pkg::OP_PULSE) begin
            if (!is_long) begin
              if (short_count_r != csvc_pkg::ShortCntMax) begin
                short_count_nxt = short_count_r + 1'b1;
              end
            end else begin
              if (short_count_r >= min_short_pulses_r) begin
                phase_nxt = csvc_pkg::PH_START;
              end
              short_count_nxt = '0;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= csvc_pkg::PH_VSYNC;
      short_count_r   <= '0;
      pixel_in_line_r <= '0;
      line_index_r    <= '0;
      captured_r      <= '0;
    end else begin
      phase_r         <= phase_nxt;
      short_count_r   <= short_count_nxt;
      pixel_in_line_r <= pixel_in_line_nxt;
      line_index_r    <= line_index_nxt;
      captured_r      <= captured_nxt;
    end
  end

  // Output register
  logic                      out_valid_r;
  logic [csvc_pkg::PixW-1:0] out_rgb_r;
  logic [csvc_pkg::ColW-1:0] out_col_r;
  logic [csvc_pkg::RowW-1:0] out_row_r;
  logic                      out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_rgb_r  <= csvc_pkg::to_rgb565(s1_word_r);
      out_col_r  <= col;
      out_row_r  <= row[csvc_pkg::RowW-1:0];
      out_last_r <= last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_row_r, out_col_r, out_rgb_r};
  assign out_tlast  = out_last_r;

  // Checks
  a_short_only_in_vsync: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != csvc_pkg::PH_VSYNC |-> short_count_r == '0)
    else $error("short pulse count nonzero outside vsync wait");

  a_last_ends_capture: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> phase_r == csvc_pkg::PH_VSYNC)
    else $error("window end pending while capture still running");

  a_col_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_col_r <= WinWLast)
    else $error("column outside window");

  a_result_needs_capture: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> phase_r == csvc_pkg::PH_CAPTURE && s1_op_r == csvc_pkg::OP_PIXEL)
    else $error("result produced outside capture");

endmodule
